@@ hdl/pnmdec_pkg.sv @@
`timescale 1ns / 1ps

package pnmdec_pkg;

  // Largest accepted image side, and the value the digit accumulator saturates at
  localparam logic [12:0] MAX_DIM = 13'd4096;
  localparam logic [12:0] DIM_SAT = 13'd4097;

  // Result kinds
  localparam logic [2:0] KIND_PIXEL    = 3'd0;
  localparam logic [2:0] KIND_HEADER   = 3'd1;
  localparam logic [2:0] KIND_NOT_PNM  = 3'd2;
  localparam logic [2:0] KIND_BAD_TYPE = 3'd3;
  localparam logic [2:0] KIND_BAD_SIZE = 3'd4;

  // Image types
  localparam logic [1:0] TYPE_BITMAP = 2'd0;
  localparam logic [1:0] TYPE_GRAY   = 2'd1;
  localparam logic [1:0] TYPE_RGB    = 2'd2;

  // Parser phases
  localparam logic [3:0] PH_WAIT_P = 4'd0;
  localparam logic [3:0] PH_TYPE   = 4'd1;
  localparam logic [3:0] PH_WS1    = 4'd2;
  localparam logic [3:0] PH_CMT1   = 4'd3;
  localparam logic [3:0] PH_WLEAD  = 4'd4;
  localparam logic [3:0] PH_WDIG   = 4'd5;
  localparam logic [3:0] PH_HLEAD  = 4'd6;
  localparam logic [3:0] PH_HDIG   = 4'd7;
  localparam logic [3:0] PH_WS2    = 4'd8;
  localparam logic [3:0] PH_CMT2   = 4'd9;
  localparam logic [3:0] PH_MAGIC  = 4'd10;
  localparam logic [3:0] PH_TAIL   = 4'd11;
  localparam logic [3:0] PH_PIX    = 4'd12;

  // Characters of the header
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_9    = 8'h39;

  typedef logic [15:0] rgb565_t;

  localparam rgb565_t PIX_BLACK = 16'h0000;
  localparam rgb565_t PIX_WHITE = 16'hffff;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // acc * 10 + digit, saturating at MAX_DIM + 1
  function automatic logic [12:0] accumulate(input logic [12:0] acc, input logic [7:0] c);
    logic [16:0] v;
    logic [3:0]  d;
    d = 4'(c - CH_0);
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {13'd0, d};
    if (acc > MAX_DIM || v > {4'd0, MAX_DIM}) begin
      return DIM_SAT;
    end
    return v[12:0];
  endfunction

endpackage

@@ hdl/pnm_raw_to_rgb565_decoder_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_stream_byte
// out_      output     out_valid/out_ready  out_result_kind, out_pixel_rgb565, out_image_type,
//                                           out_image_width, out_image_height, out_row_end,
//                                           out_image_end
//
// A byte sits in the input register and is stepped once per cycle unless the step stalls; each
// result is valid the cycle after its step. P5 pixels, P6 color bytes and most header bytes
// are done in their first step; a P4 byte gives a pixel on each step, up to 8 pixels, ending
// early at a row end. A byte that passes on to a new phase (end of whitespace, of the height
// digits, of the header) is stepped again in the new phase.
// rst_n is synchronous, active low; it returns the parser to waiting for 'P'.
// While out_ready is low and the result register is full, steps that make a result stall.

module pnm_raw_to_rgb565_decoder_top
  import pnmdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_result_kind,
  output logic [15:0] out_pixel_rgb565,
  output logic [1:0]  out_image_type,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic        out_row_end,
  output logic        out_image_end
);

  // Input register
  logic [7:0]  byte_r;
  logic        byte_vld_r;

  // Parser state
  logic [3:0]  phase_r,  phase_nxt;
  logic [1:0]  format_r, format_nxt;
  logic [12:0] width_r,  width_nxt;
  logic [12:0] height_r, height_nxt;
  logic [12:0] accum_r,  accum_nxt;
  logic [11:0] col_r,    col_nxt;
  logic [11:0] row_r,    row_nxt;
  logic [7:0]  red_r,    red_nxt;
  logic [7:0]  green_r,  green_nxt;
  logic [1:0]  slot_r,   slot_nxt;
  logic [1:0]  magic_r,  magic_nxt;
  logic [2:0]  bitpos_r, bitpos_nxt;

  // Output register
  logic        out_valid_r;
  logic [2:0]  kind_r;
  rgb565_t     pix_r;
  logic [1:0]  type_r;
  logic [12:0] ow_r, oh_r;
  logic        re_r, ie_r;

  // One step of work on the held byte
  logic        st_emit, st_done;
  logic [2:0]  st_kind;
  rgb565_t     st_pix;
  logic [1:0]  st_type;
  logic [12:0] st_w, st_h;
  logic        st_re, st_ie;

  logic        out_free, go;

  // Raster advance for a pixel
  logic [11:0] col_inc, row_inc;
  logic        col_wrap, row_wrap;
  logic        size_bad;
  logic [2:0]  bit_sel;

  assign col_inc  = col_r + 12'd1;
  assign row_inc  = row_r + 12'd1;
  assign col_wrap = ({1'b0, col_inc} >= width_r) || (col_inc == 12'd0);
  assign row_wrap = ({1'b0, row_inc} >= height_r) || (row_inc == 12'd0);
  assign size_bad = (width_r == 13'd0) || (height_r == 13'd0) ||
                    (width_r > MAX_DIM) || (height_r > MAX_DIM);
  assign bit_sel  = 3'd7 - bitpos_r;

  always_comb begin
    phase_nxt  = phase_r;
    format_nxt = format_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    accum_nxt  = accum_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    slot_nxt   = slot_r;
    magic_nxt  = magic_r;
    bitpos_nxt = bitpos_r;
    st_emit    = 1'b0;
    st_done    = 1'b1;
    st_kind    = KIND_PIXEL;
    st_pix     = '0;
    st_type    = TYPE_BITMAP;
    st_w       = '0;
    st_h       = '0;
    st_re      = 1'b0;
    st_ie      = 1'b0;

    case (phase_r)
      PH_TYPE: begin
        if (byte_r >= CH_4 && byte_r <= CH_6) begin
          format_nxt = 2'(byte_r - CH_4);
          phase_nxt  = PH_WS1;
        end else begin
          st_emit   = 1'b1;
          st_kind   = KIND_BAD_TYPE;
          phase_nxt = PH_WAIT_P;
          magic_nxt = '0;
          slot_nxt  = '0;
          accum_nxt = '0;
        end
      end
      PH_WS1: begin
        if (byte_r == CH_HASH) begin
          phase_nxt = PH_CMT1;
        end else if (!is_ws(byte_r)) begin
          phase_nxt = PH_WLEAD;
          st_done   = 1'b0;
        end
      end
      PH_CMT1: begin
        if (byte_r == CH_LF) begin
          phase_nxt = PH_WLEAD;
        end
      end
      PH_WLEAD, PH_HLEAD: begin
        if (is_digit(byte_r)) begin
          accum_nxt = {9'd0, 4'(byte_r - CH_0)};
          phase_nxt = (phase_r == PH_WLEAD) ? PH_WDIG : PH_HDIG;
        end else if (!is_ws(byte_r)) begin
          st_emit   = 1'b1;
          st_kind   = KIND_BAD_SIZE;
          phase_nxt = PH_WAIT_P;
          magic_nxt = '0;
          slot_nxt  = '0;
          accum_nxt = '0;
        end
      end
      PH_WDIG: begin
        if (is_digit(byte_r)) begin
          accum_nxt = accumulate(accum_r, byte_r);
        end else if (is_ws(byte_r)) begin
          width_nxt = accum_r;
          phase_nxt = PH_HLEAD;
        end else begin
          st_emit   = 1'b1;
          st_kind   = KIND_BAD_SIZE;
          phase_nxt = PH_WAIT_P;
          magic_nxt = '0;
          slot_nxt  = '0;
          accum_nxt = '0;
        end
      end
      PH_HDIG: begin
        if (is_digit(byte_r)) begin
          accum_nxt = accumulate(accum_r, byte_r);
        end else begin
          height_nxt = accum_r;
          phase_nxt  = PH_WS2;
          st_done    = 1'b0;
        end
      end
      PH_WS2: begin
        if (byte_r == CH_HASH) begin
          phase_nxt = PH_CMT2;
        end else if (!is_ws(byte_r)) begin
          phase_nxt = PH_MAGIC;
          magic_nxt = '0;
          st_done   = 1'b0;
        end
      end
      PH_CMT2: begin
        if (byte_r == CH_LF) begin
          phase_nxt = PH_MAGIC;
          magic_nxt = '0;
        end
      end
      PH_MAGIC, PH_TAIL: begin
        if (phase_r == PH_MAGIC &&
            byte_r == ((magic_r == 2'd0) ? CH_2 : CH_5)) begin
          magic_nxt = magic_r + 2'd1;
          if (magic_r == 2'd2) begin
            phase_nxt = PH_TAIL;
          end
        end else if (!(phase_r == PH_TAIL && is_ws(byte_r))) begin
          // header ends; the same byte is looked at again in the new phase
          st_emit   = 1'b1;
          st_done   = 1'b0;
          magic_nxt = '0;
          if (size_bad) begin
            st_kind   = KIND_BAD_SIZE;
            phase_nxt = PH_WAIT_P;
            slot_nxt  = '0;
            accum_nxt = '0;
          end else begin
            st_kind    = KIND_HEADER;
            st_type    = format_r;
            st_w       = width_r;
            st_h       = height_r;
            phase_nxt  = PH_PIX;
            col_nxt    = '0;
            row_nxt    = '0;
            slot_nxt   = '0;
            bitpos_nxt = '0;
          end
        end
      end
      PH_PIX: begin
        if (format_r == TYPE_RGB && slot_r == 2'd0) begin
          red_nxt  = byte_r;
          slot_nxt = 2'd1;
        end else if (format_r == TYPE_RGB && slot_r == 2'd1) begin
          green_nxt = byte_r;
          slot_nxt  = 2'd2;
        end else begin
          st_emit = 1'b1;
          st_kind = KIND_PIXEL;
          if (format_r == TYPE_RGB) begin
            slot_nxt = 2'd0;
            st_pix   = {red_r[7:3], green_r[7:2], byte_r[7:3]};
          end else if (format_r == TYPE_GRAY) begin
            st_pix = {byte_r[7:3], byte_r[7:2], byte_r[7:3]};
          end else begin
            // bitmap: one pixel per step, MSB first, byte ends at a row end
            st_pix     = byte_r[bit_sel] ? PIX_BLACK : PIX_WHITE;
            st_done    = col_wrap || (bitpos_r == 3'd7);
            bitpos_nxt = st_done ? 3'd0 : bitpos_r + 3'd1;
          end
          // raster advance
          col_nxt = col_inc;
          if (col_wrap) begin
            st_re   = 1'b1;
            col_nxt = '0;
            row_nxt = row_inc;
            if (row_wrap) begin
              st_ie     = 1'b1;
              row_nxt   = '0;
              phase_nxt = PH_WAIT_P;
            end
          end
        end
      end
      default: begin
        if (byte_r == CH_P) begin
          phase_nxt  = PH_TYPE;
          width_nxt  = '0;
          height_nxt = '0;
          accum_nxt  = '0;
          magic_nxt  = '0;
        end else begin
          phase_nxt = PH_WAIT_P;
          st_emit   = 1'b1;
          st_kind   = KIND_NOT_PNM;
        end
      end
    endcase
  end

  // Step control
  assign out_free = !out_valid_r || out_ready;
  assign go       = byte_vld_r && (!st_emit || out_free);
  assign in_ready = !byte_vld_r || (go && st_done);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_ready) begin
      byte_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_stream_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT_P;
      format_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      accum_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      red_r    <= '0;
      green_r  <= '0;
      slot_r   <= '0;
      magic_r  <= '0;
      bitpos_r <= '0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      format_r <= format_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      accum_r  <= accum_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      slot_r   <= slot_nxt;
      magic_r  <= magic_nxt;
      bitpos_r <= bitpos_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= go && st_emit;
    end
    if (go && st_emit) begin
      kind_r <= st_kind;
      pix_r  <= st_pix;
      type_r <= st_type;
      ow_r   <= st_w;
      oh_r   <= st_h;
      re_r   <= st_re;
      ie_r   <= st_ie;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_pixel_rgb565 = pix_r;
  assign out_image_type   = type_r;
  assign out_image_width  = ow_r;
  assign out_image_height = oh_r;
  assign out_row_end      = re_r;
  assign out_image_end    = ie_r;

  // Checks
  a_end_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ie_r |-> re_r)
    else $error("image end without row end");

  a_pixel_no_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_PIXEL |-> ow_r == 13'd0 && oh_r == 13'd0)
    else $error("pixel result carries a size");

  a_bit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    bitpos_r != 3'd0 |-> phase_r == PH_PIX && format_r == TYPE_BITMAP)
    else $error("bitmap bit position outside bitmap pixel data");

  a_accum_sat: assert property (@(posedge clk) disable iff (!rst_n)
    accum_r <= DIM_SAT)
    else $error("digit accumulator above saturation");

endmodule

@@ test/tb_pnm_raw_to_rgb565_decoder_top.sv @@
`timescale 1ns / 1ps

module tb_pnm_raw_to_rgb565_decoder_top;
  import pnmdec_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SHOWN_ERRORS = 10;

  typedef struct {
    logic [2:0]  kind;
    rgb565_t     pixel;
    logic [1:0]  itype;
    logic [12:0] width;
    logic [12:0] height;
    logic        row_end;
    logic        image_end;
  } decoded_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_result_kind;
  logic [15:0] out_pixel_rgb565;
  logic [1:0]  out_image_type;
  logic [12:0] out_image_width;
  logic [12:0] out_image_height;
  logic        out_row_end;
  logic        out_image_end;

  // Decoder state mirrored by the predictor
  logic [3:0]  prs_phase = PH_WAIT_P;
  logic [1:0]  img_kind = TYPE_BITMAP;
  logic [12:0] img_w = '0;
  logic [12:0] img_h = '0;
  logic [12:0] digits = '0;
  logic [11:0] col = '0;
  logic [11:0] row = '0;
  logic [7:0]  red_b = '0;
  logic [7:0]  green_b = '0;
  logic [1:0]  rgb_slot = '0;
  logic [1:0]  magic_cnt = '0;

  decoded_t decoded_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int kind_seen[8];
  int stall_cycles = 0;

  pnm_raw_to_rgb565_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_pixel_rgb565 (out_pixel_rgb565),
    .out_image_type   (out_image_type),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_row_end      (out_row_end),
    .out_image_end    (out_image_end)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic is_space(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  // Decimal accumulate, pinned at one past the largest side
  function automatic logic [12:0] next_dim(logic [12:0] acc, logic [7:0] c);
    int unsigned v;
    if (acc > MAX_DIM) return DIM_SAT;
    v = int'(acc) * 10 + int'(c) - int'(CH_0);
    return (v > MAX_DIM) ? DIM_SAT : 13'(v);
  endfunction

  function automatic void push_status(logic [2:0] kind);
    decoded_results.push_back('{kind, 16'h0000, 2'd0, 13'd0, 13'd0, 1'b0, 1'b0});
  endfunction

  function automatic void restart_parse();
    prs_phase = PH_WAIT_P;
    magic_cnt = '0;
    rgb_slot  = '0;
    digits    = '0;
  endfunction

  // One pixel out; advances the raster and closes the image on the last one
  function automatic void emit_pixel(rgb565_t pix);
    logic re;
    logic ie;
    re  = 1'b0;
    ie  = 1'b0;
    col = col + 12'd1;
    if (col >= img_w || col == 12'd0) begin
      re  = 1'b1;
      col = '0;
      row = row + 12'd1;
      if (row >= img_h || row == 12'd0) begin
        ie        = 1'b1;
        row       = '0;
        prs_phase = PH_WAIT_P;
      end
    end
    decoded_results.push_back('{KIND_PIXEL, pix, 2'd0, 13'd0, 13'd0, re, ie});
  endfunction

  function automatic void decode_pnm_byte(logic [7:0] c);
    logic        again;
    logic [3:0]  bit_left;
    logic [11:0] start_row;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (prs_phase)
        PH_TYPE: begin
          if (c >= CH_4 && c <= CH_6) begin
            img_kind  = 2'(c - CH_4);
            prs_phase = PH_WS1;
          end else begin
            push_status(KIND_BAD_TYPE);
            restart_parse();
          end
        end
        PH_WS1: begin
          if (c == CH_HASH) begin
            prs_phase = PH_CMT1;
          end else if (!is_space(c)) begin
            prs_phase = PH_WLEAD;
            again     = 1'b1;
          end
        end
        PH_CMT1: begin
          if (c == CH_LF) prs_phase = PH_WLEAD;
        end
        PH_WLEAD, PH_HLEAD: begin
          if (is_dec(c)) begin
            digits    = 13'(c - CH_0);
            prs_phase = (prs_phase == PH_WLEAD) ? PH_WDIG : PH_HDIG;
          end else if (!is_space(c)) begin
            push_status(KIND_BAD_SIZE);
            restart_parse();
          end
        end
        PH_WDIG: begin
          if (is_dec(c)) begin
            digits = next_dim(digits, c);
          end else if (is_space(c)) begin
            img_w     = digits;
            prs_phase = PH_HLEAD;
          end else begin
            push_status(KIND_BAD_SIZE);
            restart_parse();
          end
        end
        PH_HDIG: begin
          if (is_dec(c)) begin
            digits = next_dim(digits, c);
          end else begin
            img_h     = digits;
            prs_phase = PH_WS2;
            again     = 1'b1;
          end
        end
        PH_WS2: begin
          if (c == CH_HASH) begin
            prs_phase = PH_CMT2;
          end else if (!is_space(c)) begin
            prs_phase = PH_MAGIC;
            magic_cnt = '0;
            again     = 1'b1;
          end
        end
        PH_CMT2: begin
          if (c == CH_LF) begin
            prs_phase = PH_MAGIC;
            magic_cnt = '0;
          end
        end
        PH_MAGIC, PH_TAIL: begin
          if (prs_phase == PH_MAGIC && c == ((magic_cnt == 2'd0) ? CH_2 : CH_5)) begin
            magic_cnt = magic_cnt + 2'd1;
            if (magic_cnt >= 2'd3) prs_phase = PH_TAIL;
          end else if (!(prs_phase == PH_TAIL && is_space(c))) begin
            // header closes; this byte gets handled again
            magic_cnt = '0;
            if (img_w == 13'd0 || img_h == 13'd0 || img_w > MAX_DIM || img_h > MAX_DIM) begin
              push_status(KIND_BAD_SIZE);
              restart_parse();
            end else begin
              decoded_results.push_back('{KIND_HEADER, 16'h0000, img_kind, img_w, img_h,
                                          1'b0, 1'b0});
              prs_phase = PH_PIX;
              col       = '0;
              row       = '0;
              rgb_slot  = '0;
            end
            again = 1'b1;
          end
        end
        PH_PIX: begin
          if (img_kind == TYPE_RGB) begin
            if (rgb_slot == 2'd0) begin
              red_b    = c;
              rgb_slot = 2'd1;
            end else if (rgb_slot == 2'd1) begin
              green_b  = c;
              rgb_slot = 2'd2;
            end else begin
              rgb_slot = 2'd0;
              emit_pixel({red_b[7:3], green_b[7:2], c[7:3]});
            end
          end else if (img_kind == TYPE_GRAY) begin
            emit_pixel({c[7:3], c[7:2], c[7:3]});
          end else begin
            // bitmap: MSB first, stop at the row's end
            bit_left  = 4'd8;
            start_row = row;
            while (bit_left != 4'd0 && prs_phase == PH_PIX && row == start_row) begin
              bit_left = bit_left - 4'd1;
              emit_pixel(c[bit_left[2:0]] ? PIX_BLACK : PIX_WHITE);
            end
          end
        end
        default: begin
          if (c == CH_P) begin
            prs_phase = PH_TYPE;
            img_w     = '0;
            img_h     = '0;
            digits    = '0;
            magic_cnt = '0;
          end else begin
            prs_phase = PH_WAIT_P;
            push_status(KIND_NOT_PNM);
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stall and compare
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    decoded_t want;
    decoded_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_result_kind, out_pixel_rgb565, out_image_type, out_image_width,
              out_image_height, out_row_end, out_image_end};
      results_seen++;
      kind_seen[got.kind]++;
      if (decoded_results.size() == 0) begin
        if (mismatches < SHOWN_ERRORS)
          $display("%0t: result with nothing pending: kind=%0d pix=%h type=%0d w=%0d h=%0d",
                   $realtime, got.kind, got.pixel, got.itype, got.width, got.height);
        mismatches++;
      end else begin
        want = decoded_results.pop_front();
        if (got.kind !== want.kind || got.pixel !== want.pixel || got.itype !== want.itype ||
            got.width !== want.width || got.height !== want.height ||
            got.row_end !== want.row_end || got.image_end !== want.image_end) begin
          if (mismatches < SHOWN_ERRORS) begin
            $display("%0t: mismatch on result %0d", $realtime, results_seen);
            $display("  want kind=%0d pix=%h type=%0d w=%0d h=%0d row_end=%b image_end=%b",
                     want.kind, want.pixel, want.itype, want.width, want.height,
                     want.row_end, want.image_end);
            $display("  got  kind=%0d pix=%h type=%0d w=%0d h=%0d row_end=%b image_end=%b",
                     got.kind, got.pixel, got.itype, got.width, got.height,
                     got.row_end, got.image_end);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no request moving on either side
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
    $display("pnm_raw_to_rgb565_decoder_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Called and returns at a falling edge; predicts once the request is taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_stream_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_pnm_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(3))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // A byte that no header field accepts
  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (is_dec(b) || is_space(b) || b == CH_HASH || b == CH_P) b = "-";
    return b;
  endfunction

  task automatic send_ws(input int n);
    repeat (n) send_byte(pick_ws());
  endtask

  task automatic send_comment();
    logic [7:0] b;
    send_byte(CH_HASH);
    repeat ($urandom_range(3)) begin
      b = 8'($urandom_range(255));
      send_byte((b == CH_LF) ? CH_SP : b);
    end
    send_byte(CH_LF);
  endtask

  // Feed bytes until the parser is back to looking for 'P'
  task automatic finish_image();
    while (prs_phase != PH_WAIT_P) begin
      if (prs_phase == PH_CMT1 || prs_phase == PH_CMT2) send_byte(CH_LF);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  // Side length text: mostly small, sometimes zero or past the limit
  function automatic string dim_text(input int unsigned small_max);
    int unsigned r;
    string       s;
    r = $urandom_range(99);
    if (r < 6) s = "0";
    else if (r < 11) s = $urandom_range(1) ? "4097" : "99999";
    else s = $sformatf("%0d", $urandom_range(small_max, 1));
    if ($urandom_range(4) == 0) s = {"0", s};
    return s;
  endfunction

  task automatic send_pnm_image();
    logic [7:0]  tdigit;
    logic [7:0]  b;
    int unsigned tail;
    tdigit = CH_4 + 8'($urandom_range(2));
    send_byte(CH_P);
    send_byte(tdigit);
    send_ws($urandom_range(2));
    if ($urandom_range(3) == 0) send_comment();
    send_text(dim_text((tdigit == CH_4) ? 17 : 9));
    send_ws($urandom_range(2, 1));
    send_text(dim_text(3));
    tail = $urandom_range(9);
    if (tail < 6) begin
      send_ws($urandom_range(2, 1));
      if ($urandom_range(3) == 0) send_comment();
      send_text("255");
      send_ws($urandom_range(2));
    end else if (tail < 8) begin
      // "255" cut short
      send_text((tail == 6) ? " 2" : " 25");
    end else begin
      // no "255": data right after the height
      b = 8'($urandom_range(255));
      send_byte(is_dec(b) ? (b ^ 8'h80) : b);
    end
    finish_image();
  endtask

  task automatic send_broken_header();
    logic [7:0] b;
    case ($urandom_range(3))
      0: begin
        repeat ($urandom_range(3, 1)) begin
          b = 8'($urandom_range(255));
          send_byte((b == CH_P) ? (b ^ 8'h80) : b);
        end
      end
      1: begin
        b = 8'($urandom_range(255));
        if (b >= CH_4 && b <= CH_6) b = b ^ 8'h40;
        send_byte(CH_P);
        send_byte(b);
      end
      2: begin
        send_text($sformatf("P%0d ", $urandom_range(6, 4)));
        send_byte(pick_junk());
      end
      default: begin
        send_text($sformatf("P%0d %0d", $urandom_range(6, 4), $urandom_range(99, 1)));
        send_byte(pick_junk());
      end
    endcase
    finish_image();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_header_errors();
    send_byte(8'h00);
    send_byte(8'hff);
    send_text("P3");
    send_text("P7");
  endtask

  // 1x1 gray, 1x1 color and a 2-wide bitmap row, each with "255" left out
  task automatic test_each_format();
    send_text("P51 1");
    send_byte(8'hff);
    send_text("P61 1");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_text("P42 1");
    send_byte(8'hbf);
    finish_image();
  endtask

  task automatic test_zero_size();
    send_text("P50 1x");
    finish_image();
  endtask

  task automatic test_random_streams(input int s_pct, input int r_pct, input int n);
    int stop_at;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at       = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 20) send_broken_header();
      else send_pnm_image();
    end
  endtask

  // Largest side parsed next to a zero side, and one past the largest side
  task automatic test_size_limits();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_text("P5 4096 0 255 ");
    finish_image();
    send_text("P5 1 4097\n255 ");
    finish_image();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 45;
    test_header_errors();
    test_each_format();
    test_zero_size();
    test_random_streams(25, 45, 60);
    test_random_streams(45, 25, 60);
    test_random_streams(0, 0, 60);
    test_size_limits();
    in_valid = 1'b0;

    while (decoded_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    mismatches += decoded_results.size();

    $display("covered %0d input bytes, %0d results: %0d headers, %0d pixels", bytes_sent,
             results_seen, kind_seen[KIND_HEADER], kind_seen[KIND_PIXEL]);
    $display("error reports: %0d not PNM, %0d bad type, %0d bad size; %0d mismatches",
             kind_seen[KIND_NOT_PNM], kind_seen[KIND_BAD_TYPE], kind_seen[KIND_BAD_SIZE],
             mismatches);
    if (mismatches == 0) begin
      $display("pnm_raw_to_rgb565_decoder_top regression: pass");
    end else begin
      $display("pnm_raw_to_rgb565_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pnmdec_pkg.sv
hdl/pnm_raw_to_rgb565_decoder_top.sv
test/tb_pnm_raw_to_rgb565_decoder_top.sv
